@@ rtl/core/stoi_pkg.sv @@
package stoi_pkg;

    // Widths fixed by the item layout
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned BASE_W        = 6;
    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned END_OFFSET_W  = 16;
    localparam int unsigned DIGIT_W       = 6;
    localparam int unsigned IN_TDATA_W    = 8;
    localparam int unsigned OUT_TDATA_W   = 88;
    localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - VALUE_W - 1 - END_OFFSET_W;

    // Default for the byte counter width
    localparam int unsigned OFFSET_BITS_DEF = 16;

    // Base register codes
    localparam logic [BASE_W-1:0] BASE_AUTO   = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE    = 6'd1;
    localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;

    // Characters
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_OFS = 8'd55;   // 'A' - 10
    localparam logic [CHAR_W-1:0] CHAR_LC_OFS = 8'd87;   // 'a' - 10
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_LC_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UC_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;

    // Digit code for a byte that is no digit in any base
    localparam logic [DIGIT_W-1:0] NOT_DIGIT  = 6'd63;

    // Saturation limits
    localparam logic [VALUE_W-1:0] POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_DIGITS,
        DS_OVER
    } t_dstat;

    // Map a byte to its digit value, either letter case
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            d = b - CHAR_ZERO;
        end else if (b >= CHAR_UC_A && b <= CHAR_UC_Z) begin
            d = b - CHAR_UC_OFS;
        end else if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
            d = b - CHAR_LC_OFS;
        end else begin
            d = CHAR_W'(NOT_DIGIT);
        end
        return d[DIGIT_W-1:0];
    endfunction

    // C-locale whitespace
    function automatic logic is_space(input logic [CHAR_W-1:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

endpackage

@@ rtl/core/string_to_signed_integer_parser.sv @@
// Channel   | Dir | tdata (low bit up)                          | tuser
// ----------+-----+---------------------------------------------+---------------
// s_axis    | in  | [7:0] char_byte                             | [0] starts_string
// m_axis    | out | [63:0] value, [64] out_of_range,            | -
//           |     | [80:65] end_offset, [87:81] zero            |
// cfg       | in  | i_cfg_wdata[5:0] base_setting, on i_cfg_wen | -
//
// One item per cycle unless a stalled output holds the input: every byte passes an input register, then one
// multiply-add by the base with an overflow compare updates the parse state.
// A result is written to the result register when the byte that ends the string leaves the input register.
// Reset (synchronous, active low) leaves the parser waiting for a start, base 10.
// A stalled output holds its item; the input register still takes one more byte,
// after which s_axis ready drops until the result is taken.
module string_to_signed_integer_parser
    import stoi_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wen,
    input  logic [BASE_W-1:0]       i_cfg_wdata,     // [5:0] base_setting
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,  // [7:0] char_byte
    input  logic                    i_s_axis_tuser,  // [0] starts_string
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata   // [63:0] value, [64] out_of_range,
                                                     // [80:65] end_offset, rest zero
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam int unsigned MAC_W = VALUE_W + BASE_W + 1;

    // Registers
    logic                     r_in_valid;
    logic [CHAR_W-1:0]        r_in_char;
    logic                     r_in_start;
    logic [BASE_W-1:0]        r_base;
    t_phase                   r_phase, n_phase;
    logic                     r_neg, n_neg;
    logic [VALUE_W-1:0]       r_acc, n_acc;
    t_dstat                   r_dstat, n_dstat;
    logic [BASE_W-1:0]        r_ebase, n_ebase;
    logic [OFFSET_BITS-1:0]   r_pos, n_pos;
    logic                     r_out_valid;
    logic [VALUE_W-1:0]       r_out_value;
    logic                     r_out_oor;
    logic [END_OFFSET_W-1:0]  r_out_off;

    // Step logic
    logic                     w_adv;
    logic                     w_skip;
    logic                     w_first;
    logic                     w_step;
    logic [OFFSET_BITS-1:0]   w_cur;
    logic [DIGIT_W-1:0]       w_dig;
    logic [BASE_W-1:0]        w_eb;
    logic [MAC_W-1:0]         w_mac;
    logic [MAC_W-1:0]         w_lim;
    logic                     w_emit;
    logic [VALUE_W-1:0]       w_val;
    logic                     w_oor;
    logic [END_OFFSET_W-1:0]  w_off;

    // Advance the held byte when the result register is free or draining
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_DEC;
        end else if (i_cfg_wen) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char  <= i_s_axis_tdata[CHAR_W-1:0];
            r_in_start <= i_s_axis_tuser;
        end
    end

    // Work out the parse state and any result for the held byte
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_dstat = r_dstat;
        n_ebase = r_ebase;
        n_pos   = r_pos;
        w_skip  = 1'b0;
        w_first = 1'b0;
        w_step  = 1'b0;
        w_cur   = '0;
        w_eb    = BASE_DEC;
        w_mac   = '0;
        w_lim   = '0;
        w_emit  = 1'b0;
        w_val   = '0;
        w_oor   = 1'b0;
        w_off   = '0;
        w_dig   = digit_of(r_in_char);

        // A start drops any unfinished string and latches the base
        if (r_in_start) begin
            n_phase = PH_LEAD;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_dstat = DS_NONE;
            n_pos   = '0;
            n_ebase = r_base;
            if (r_base == BASE_ONE || r_base > BASE_MAX) begin
                n_pos   = OFFSET_BITS'(1);
                n_phase = PH_DONE;
                w_emit  = 1'b1;
                w_skip  = 1'b1;
            end
        end

        if (!w_skip) begin
            w_cur = n_pos;
            if (n_phase != PH_DONE && n_pos != POS_MAX) begin
                n_pos = n_pos + 1'b1;
            end

            case (n_phase)
                PH_LEAD: begin
                    if (is_space(r_in_char)) begin
                        n_phase = PH_LEAD;
                    end else if (r_in_char == CHAR_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGNED;
                    end else if (r_in_char == CHAR_PLUS) begin
                        n_phase = PH_SIGNED;
                    end else begin
                        w_first = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    w_first = 1'b1;
                end
                PH_ZERO: begin
                    if (r_in_char == CHAR_LC_X || r_in_char == CHAR_UC_X) begin
                        // Keep the index of the x while the prefix is open
                        n_acc   = VALUE_W'(w_cur);
                        n_phase = PH_PREFIX;
                    end else begin
                        if (n_ebase == BASE_AUTO) begin
                            n_ebase = BASE_OCT;
                        end
                        w_step = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    n_ebase = BASE_HEX;
                    if (w_dig < DIGIT_W'(BASE_HEX)) begin
                        n_acc   = VALUE_W'(w_dig);
                        n_dstat = DS_DIGITS;
                        n_phase = PH_DIGITS;
                    end else begin
                        // Prefix without a hex digit: only the zero counts
                        w_emit  = 1'b1;
                        w_off   = END_OFFSET_W'(n_acc);
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    w_step = 1'b1;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            // First character after whitespace and sign
            if (w_first) begin
                if ((n_ebase == BASE_AUTO || n_ebase == BASE_HEX)
                    && r_in_char == CHAR_ZERO) begin
                    n_acc   = '0;
                    n_dstat = DS_DIGITS;
                    n_phase = PH_ZERO;
                end else begin
                    if (n_ebase == BASE_AUTO) begin
                        n_ebase = BASE_DEC;
                    end
                    w_step = 1'b1;
                end
            end

            // Accumulate one digit or finish the string
            if (w_step) begin
                w_eb    = (n_ebase < BASE_MIN || n_ebase > BASE_MAX) ? BASE_DEC : n_ebase;
                n_phase = PH_DIGITS;
                if (w_dig >= w_eb) begin
                    w_emit  = 1'b1;
                    n_phase = PH_DONE;
                    case (n_dstat)
                        DS_NONE: begin
                            w_off = '0;
                        end
                        DS_OVER: begin
                            w_val = n_neg ? NEG_LIMIT : POS_LIMIT;
                            w_oor = 1'b1;
                            w_off = END_OFFSET_W'(w_cur);
                        end
                        default: begin
                            w_val = n_neg ? (VALUE_W'(0) - n_acc) : n_acc;
                            w_off = END_OFFSET_W'(w_cur);
                        end
                    endcase
                end else begin
                    w_mac = MAC_W'(n_acc) * MAC_W'(w_eb) + MAC_W'(w_dig);
                    w_lim = MAC_W'(POS_LIMIT) + MAC_W'(n_neg);
                    if (n_dstat == DS_OVER || w_mac > w_lim) begin
                        n_dstat = DS_OVER;
                    end else begin
                        n_acc   = w_mac[VALUE_W-1:0];
                        n_dstat = DS_DIGITS;
                    end
                end
            end
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_dstat <= DS_NONE;
            r_ebase <= BASE_DEC;
            r_pos   <= '0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_dstat <= n_dstat;
            r_ebase <= n_ebase;
            r_pos   <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_value <= w_val;
            r_out_oor   <= w_oor;
            r_out_off   <= w_off;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0), r_out_off, r_out_oor, r_out_value};

    // A string that gives its result leaves the parser waiting for a start
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (r_phase == PH_DONE))
        else $error("parser not idle after a result");

    // A saturated result carries one of the two limits
    a_oor_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |->
            (r_out_value == POS_LIMIT || r_out_value == NEG_LIMIT))
        else $error("out_of_range without a saturated value");

    // The accumulator never passes the limit for its sign
    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIGITS && r_dstat == DS_DIGITS) |->
            ((r_neg && r_acc <= NEG_LIMIT) || (!r_neg && r_acc <= POS_LIMIT)))
        else $error("accumulator beyond its limit");

    // Overflow only arises in the digit phase
    a_over_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dstat == DS_OVER) |-> (r_phase == PH_DIGITS || r_phase == PH_DONE))
        else $error("overflow outside the digit phase");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench
    import stoi_pkg::*;
();

    localparam int        CYCLE_LIMIT  = 4_000_000;
    localparam int        RANDOM_ITEMS = 1400;
    localparam int        PHASE_ITEMS  = 160;
    localparam int        SETTLE_GAP   = 4;
    localparam int        NO_TERM      = -1;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

    typedef struct packed {
        logic [VALUE_W-1:0]      value;
        logic                    oor;
        logic [END_OFFSET_W-1:0] off;
    } parse_result_t;

    typedef struct {
        logic [BASE_W-1:0]  base;
        bit                 start;
        string              text;
        int                 term;
        bit                 typed;
        logic [VALUE_W-1:0] value;
        bit                 oor;
        int                 off;
    } probe_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_HOLD
    } rx_mode_t;

    // Block ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [BASE_W-1:0]      i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Parser image kept alongside the block
    logic [BASE_W-1:0]  base_reg = BASE_DEC;
    t_phase             ph = PH_DONE;
    logic               neg = 1'b0;
    logic [VALUE_W-1:0] acc = '0;
    t_dstat             dstat = DS_NONE;
    logic [BASE_W-1:0]  ebase = BASE_DEC;
    logic [15:0]        pos = '0;

    parse_result_t expected_q [$];
    parse_result_t want;
    parse_result_t typed_res;
    bit            typed_on = 1'b0;
    bit            start_pending = 1'b0;
    int            burst_left = 0;
    int            bytes_sent = 0;
    int            fail_count = 0;
    int            cycle_count = 0;
    rx_mode_t      stall_mode = RX_OPEN;
    int            stall_left = 0;
    int            stall_hold = 0;
    int            stall_tick = 0;

    probe_row_t probe_rows [$] = '{
        '{BASE_DEC, 1'b1, "", 0, 1'b1, 64'd0, 1'b0, 0},
        '{BASE_DEC, 1'b1, "9223372036854775807", 0, 1'b1, POS_LIMIT, 1'b0, 19},
        '{BASE_DEC, 1'b1, "9223372036854775808", 0, 1'b1, POS_LIMIT, 1'b1, 19},
        '{BASE_DEC, 1'b1, "-9223372036854775808", 0, 1'b1, NEG_LIMIT, 1'b0, 20},
        '{BASE_DEC, 1'b1, "-99999999999999999999", int'(" "), 1'b1, NEG_LIMIT, 1'b1, 21},
        '{BASE_DEC, 1'b1, "\040\011\012\013\014\015+42", int'("z"), 1'b1, 64'd42, 1'b0, 9},
        '{BASE_DEC, 1'b1, "-", int'(" "), 1'b1, 64'd0, 1'b0, 0},
        '{BASE_DEC, 1'b1, "\3775", 0, 1'b1, 64'd0, 1'b0, 0},
        '{BASE_DEC, 1'b1, "12", NO_TERM, 1'b0, 64'd0, 1'b0, 0},
        '{BASE_DEC, 1'b1, "34", 0, 1'b1, 64'd34, 1'b0, 2},
        '{BASE_DEC, 1'b0, "99", 0, 1'b0, 64'd0, 1'b0, 0},
        '{BASE_AUTO, 1'b1, "0x1F", 0, 1'b1, 64'd31, 1'b0, 4},
        '{BASE_AUTO, 1'b1, "0X", int'("g"), 1'b1, 64'd0, 1'b0, 1},
        '{BASE_AUTO, 1'b1, "0777", int'("8"), 1'b1, 64'd511, 1'b0, 4},
        '{BASE_AUTO, 1'b1, "0", int'("8"), 1'b1, 64'd0, 1'b0, 1},
        '{BASE_AUTO, 1'b1, "123", int'("a"), 1'b1, 64'd123, 1'b0, 3},
        '{BASE_HEX, 1'b1, "-0xfF", 0, 1'b1, -64'd255, 1'b0, 5},
        '{BASE_HEX, 1'b1, "8000000000000000", 0, 1'b1, POS_LIMIT, 1'b1, 16},
        '{BASE_HEX, 1'b1, "-8000000000000000", 0, 1'b1, NEG_LIMIT, 1'b0, 17},
        '{BASE_MAX, 1'b1, "Zz", int'("!"), 1'b1, 64'd1295, 1'b0, 2},
        '{BASE_MIN, 1'b1, "101", int'("2"), 1'b1, 64'd5, 1'b0, 3},
        '{BASE_ONE, 1'b1, "", int'("7"), 1'b1, 64'd0, 1'b0, 0},
        '{6'd63, 1'b1, "12", 0, 1'b1, 64'd0, 1'b0, 0},
        '{6'd37, 1'b1, "1", NO_TERM, 1'b1, 64'd0, 1'b0, 0}
    };

    string_to_signed_integer_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Digit value of a character, 63 when it is no digit at all
    function automatic logic [5:0] char_digit(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return 6'(c - CHAR_UC_A + 8'd10);
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return 6'(c - CHAR_LC_A + 8'd10);
        return NOT_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Close the string with the given value, flag and end offset
    function automatic bit close_string(input logic [VALUE_W-1:0] v, input logic f,
                                        input logic [15:0] o, output parse_result_t r);
        r.value = v;
        r.oor   = f;
        r.off   = o;
        ph      = PH_DONE;
        return 1'b1;
    endfunction

    // Accumulate one digit with saturation, or finish on a non-digit
    function automatic bit take_digit(input logic [7:0] c, input logic [15:0] cur,
                                      output parse_result_t r);
        logic [5:0]         d;
        logic [5:0]         eb;
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] cutoff;
        logic [VALUE_W-1:0] cutlim;
        d  = char_digit(c);
        eb = ebase;
        ph = PH_DIGITS;
        r  = '0;
        if (eb < BASE_MIN || eb > BASE_MAX) eb = BASE_DEC;
        if (d >= eb) begin
            if (dstat == DS_NONE) return close_string('0, 1'b0, '0, r);
            if (dstat == DS_OVER) return close_string(neg ? NEG_LIMIT : POS_LIMIT, 1'b1, cur, r);
            return close_string(neg ? 64'd0 - acc : acc, 1'b0, cur, r);
        end
        lim    = neg ? NEG_LIMIT : POS_LIMIT;
        cutoff = lim / 64'(eb);
        cutlim = lim % 64'(eb);
        if (dstat == DS_OVER || acc > cutoff || (acc == cutoff && 64'(d) > cutlim)) begin
            dstat = DS_OVER;
        end else begin
            acc   = acc * 64'(eb) + 64'(d);
            dstat = DS_DIGITS;
        end
        return 1'b0;
    endfunction

    // First character after blanks and sign: a leading zero may open a prefix
    function automatic bit lead_digit(input logic [7:0] c, input logic [15:0] cur,
                                      output parse_result_t r);
        r = '0;
        if ((ebase == BASE_AUTO || ebase == BASE_HEX) && c == CHAR_ZERO) begin
            acc   = '0;
            dstat = DS_DIGITS;
            ph    = PH_ZERO;
            return 1'b0;
        end
        if (ebase == BASE_AUTO) ebase = BASE_DEC;
        return take_digit(c, cur, r);
    endfunction

    // Advance the parser image by one accepted character
    function automatic bit parse_char(input logic [7:0] c, input logic st,
                                      output parse_result_t r);
        logic [15:0] cur;
        bit          hit;
        hit = 1'b0;
        r   = '0;
        if (st) begin
            ph    = PH_LEAD;
            neg   = 1'b0;
            acc   = '0;
            dstat = DS_NONE;
            pos   = '0;
            ebase = base_reg;
            if (base_reg == BASE_ONE || base_reg > BASE_MAX) begin
                pos = 16'd1;
                return close_string('0, 1'b0, '0, r);
            end
        end
        cur = pos;
        if (ph != PH_DONE && pos != OFFSET_TOP) pos = pos + 16'd1;
        case (ph)
            PH_LEAD: begin
                if (is_blank(c)) begin
                end else if (c == CHAR_MINUS) begin
                    neg = 1'b1;
                    ph  = PH_SIGNED;
                end else if (c == CHAR_PLUS) begin
                    ph = PH_SIGNED;
                end else begin
                    hit = lead_digit(c, cur, r);
                end
            end
            PH_SIGNED: hit = lead_digit(c, cur, r);
            PH_ZERO: begin
                if (c == CHAR_LC_X || c == CHAR_UC_X) begin
                    acc = 64'(cur);
                    ph  = PH_PREFIX;
                end else begin
                    if (ebase == BASE_AUTO) ebase = BASE_OCT;
                    hit = take_digit(c, cur, r);
                end
            end
            PH_PREFIX: begin
                ebase = BASE_HEX;
                if (char_digit(c) < 6'(BASE_HEX)) begin
                    acc   = 64'(char_digit(c));
                    dstat = DS_DIGITS;
                    ph    = PH_DIGITS;
                end else begin
                    hit = close_string('0, 1'b0, acc[15:0], r);
                end
            end
            PH_DIGITS: hit = take_digit(c, cur, r);
            default:   ph = PH_DONE;
        endcase
        return hit;
    endfunction

    // Hand one character over, in bursts with random gaps, and predict it
    task automatic send_byte(input logic [7:0] c);
        parse_result_t res;
        bit            hit;
        int            gap_len;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(100, 400);
                gap_len    = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_len    = $urandom_range(0, 6);
            end
            if (gap_len > 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap_len - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tuser  <= start_pending;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        hit = parse_char(c, start_pending, res);
        if (hit) expected_q.push_back(typed_on ? typed_res : res);
        start_pending = 1'b0;
        bytes_sent++;
    endtask

    // Hold the input idle until every result is back, then a little longer
    task automatic settle(input int extra);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] b);
        settle(SETTLE_GAP);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= b;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        base_reg = b;
    endtask

    // One random string: mostly well-formed numbers, some noise and broken ones
    task automatic send_random_string();
        int         kind;
        int         n;
        int         eb;
        int         w;
        logic [5:0] d;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        start_pending = 1'b1;
        if (kind == 0) begin
            // noise
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            // stray characters with no start
            start_pending = 1'b0;
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                w = $urandom_range(8, 13);
                send_byte(w == 8 ? CHAR_SPACE : 8'(w));
            end
            case ($urandom_range(0, 3))
                0:       send_byte(CHAR_MINUS);
                1:       send_byte(CHAR_PLUS);
                default: ;
            endcase
            eb = (base_reg == BASE_AUTO) ? 10 : int'(base_reg);
            if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && $urandom_range(0, 2) == 0) begin
                send_byte(CHAR_ZERO);
                send_byte($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
                eb = 16;
            end else if (base_reg == BASE_AUTO && $urandom_range(0, 2) == 0) begin
                send_byte(CHAR_ZERO);
                eb = 8;
            end
            if (eb < 2 || eb > 36) eb = 10;
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
            repeat (n) begin
                d = 6'($urandom_range(0, eb - 1));
                if (d < 6'd10) c = CHAR_ZERO + 8'(d);
                else if ($urandom_range(0, 1)) c = CHAR_UC_A + 8'(d) - 8'd10;
                else c = CHAR_LC_A + 8'(d) - 8'd10;
                send_byte(c);
            end
            // end the string, or leave it open for the next start to drop
            case ($urandom_range(0, 5))
                0, 1:    send_byte(CHAR_NUL);
                2:       send_byte(CHAR_SPACE);
                3:       send_byte(8'($urandom_range(0, 255)));
                4:       ;
                default: send_byte(CHAR_DOT);
            endcase
        end
    endtask

    // Receiver stall patterns
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_m_axis_tready <= (stall_tick % 5) != 0;
            default: begin
                if (stall_hold != 0) begin
                    stall_hold--;
                    i_m_axis_tready <= 1'b0;
                end else begin
                    i_m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_hold = $urandom_range(4, 20);
                end
            end
        endcase
    end

    // Compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("result item with nothing expected: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_m_axis_tdata[63:0] !== want.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(o_m_axis_tdata[63:0]));
                    fail_count++;
                end
                if (o_m_axis_tdata[64] !== want.oor) begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, o_m_axis_tdata[64]);
                    fail_count++;
                end
                if (o_m_axis_tdata[80:65] !== want.off) begin
                    $error("end_offset: expected %0d, got %0d", want.off, o_m_axis_tdata[80:65]);
                    fail_count++;
                end
                if (o_m_axis_tdata[OUT_TDATA_W-1:81] !== '0) begin
                    $error("padding: expected 0, got %h", o_m_axis_tdata[OUT_TDATA_W-1:81]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int          phase;
        int          target;
        int          phase_end;
        int          k;
        logic [BASE_W-1:0] pick;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings
        foreach (probe_rows[i]) begin
            if (probe_rows[i].base != base_reg) write_base(probe_rows[i].base);
            typed_on  = probe_rows[i].typed;
            typed_res = '{value: probe_rows[i].value, oor: probe_rows[i].oor,
                          off: 16'(probe_rows[i].off)};
            start_pending = probe_rows[i].start;
            for (k = 0; k < probe_rows[i].text.len(); k++) send_byte(probe_rows[i].text[k]);
            if (probe_rows[i].term != NO_TERM) send_byte(8'(probe_rows[i].term));
            typed_on = 1'b0;
        end

        // Random phases, each under its own base
        target = bytes_sent + RANDOM_ITEMS;
        phase  = 0;
        while (bytes_sent < target) begin
            case (phase)
                0:       pick = BASE_AUTO;
                1:       pick = BASE_MAX;
                2:       pick = BASE_HEX;
                3:       pick = BASE_MIN;
                4:       pick = BASE_OCT;
                5:       pick = BASE_DEC;
                default: begin
                    case ($urandom_range(0, 11))
                        0:       pick = 6'($urandom_range(37, 63));
                        1:       pick = BASE_ONE;
                        default: pick = 6'($urandom_range(0, 36));
                    endcase
                end
            endcase
            write_base(pick);
            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end) send_random_string();
            // close whatever is still open
            start_pending = 1'b1;
            send_byte(CHAR_NUL);
            phase++;
        end

        settle(8);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
